/* src/ps2mc_pkg.sv */
// ----------------------------------------------------------------------------
// ps2mc_pkg
// shared types and constants of the ps2 mouse packet cursor block
// ----------------------------------------------------------------------------
package ps2mc_pkg;

  localparam int CoordBits  = 12;
  localparam int CoordMax   = (1 << CoordBits) - 1;
  localparam int ScreenBits = 12;
  localparam int CursorBits = 8;
  localparam int PortXyBits = 12;
  localparam int DeltaBits  = 9;
  localparam int CfgIdxBits = 2;

  localparam logic [CoordBits-1:0] PosReset = CoordBits'(150);

  localparam logic [CfgIdxBits-1:0] CFG_SCREEN_W = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_SCREEN_H = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_CURSOR_W = 2'd2;
  localparam logic [CfgIdxBits-1:0] CFG_CURSOR_H = 2'd3;

  typedef struct packed {
    logic [ScreenBits-1:0] screen_w;
    logic [ScreenBits-1:0] screen_h;
    logic [CursorBits-1:0] cursor_w;
    logic [CursorBits-1:0] cursor_h;
  } cfg_t;

  typedef struct packed {
    logic                  left_button;
    logic                  right_button;
    logic                  middle_button;
    logic                  x_overflow;
    logic                  y_overflow;
    logic [DeltaBits-1:0]  delta_x;
    logic [DeltaBits-1:0]  delta_y;
    logic [PortXyBits-1:0] cursor_x;
    logic [PortXyBits-1:0] cursor_y;
  } res_t;

endpackage

/* src/ps2mc_in_stage.sv */
// ----------------------------------------------------------------------------
// ps2mc_in_stage
// input register for raw mouse bytes
// ----------------------------------------------------------------------------
module ps2mc_in_stage import ps2mc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_mouse_byte,
  input  logic       adv,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign in_ready = !valid_r || adv;

  always_comb begin
    valid_nxt = valid_r;
    if (adv) valid_nxt = 1'b0;
    if (in_valid && in_ready) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) byte_r <= in_mouse_byte;
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

endmodule

/* src/ps2mc_decode.sv */
// ----------------------------------------------------------------------------
// ps2mc_decode
// packet framing and clamped cursor update, one byte per transfer
// ----------------------------------------------------------------------------
module ps2mc_decode import ps2mc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [7:0] byte_in,
  input  cfg_t       cfg,
  output logic       res_valid,
  output res_t       res
);

  typedef enum logic [2:0] {
    PKT_IDLE = 3'b001,
    PKT_HDR  = 3'b010,
    PKT_XB   = 3'b100
  } pkt_state_t;

  typedef logic signed [CoordBits+1:0] sum_t;

  pkt_state_t           state_r, state_nxt;
  logic [7:0]           hdr_r, hdr_nxt;
  logic [7:0]           xb_r, xb_nxt;
  logic [CoordBits-1:0] pos_x_r, pos_x_nxt;
  logic [CoordBits-1:0] pos_y_r, pos_y_nxt;

  logic signed [DeltaBits-1:0] dx;
  logic signed [DeltaBits-1:0] dy;
  logic [CoordBits-1:0]        lim_x;
  logic [CoordBits-1:0]        lim_y;
  sum_t                        sum_x;
  sum_t                        sum_y;
  logic [CoordBits-1:0]        new_x;
  logic [CoordBits-1:0]        new_y;
  logic                        done;

  function automatic logic [CoordBits-1:0] axis_limit(
    input logic [ScreenBits-1:0] screen,
    input logic [CursorBits-1:0] cursor
  );
    logic signed [ScreenBits:0] diff;
    diff = $signed({1'b0, screen}) - $signed({{(ScreenBits-CursorBits+1){1'b0}}, cursor});
    if (diff < 0) return '0;
    if (int'(diff) > CoordMax) return CoordBits'(CoordMax);
    return CoordBits'(diff);
  endfunction

  function automatic logic [CoordBits-1:0] clamp_axis(
    input sum_t                 sum,
    input logic [CoordBits-1:0] lim
  );
    if (sum < 0) return '0;
    if (sum > $signed({2'b00, lim})) return lim;
    return sum[CoordBits-1:0];
  endfunction

  assign dx    = $signed({hdr_r[4], xb_r});
  assign dy    = $signed({hdr_r[5], byte_in});
  assign lim_x = axis_limit(cfg.screen_w, cfg.cursor_w);
  assign lim_y = axis_limit(cfg.screen_h, cfg.cursor_h);
  assign sum_x = $signed({2'b00, pos_x_r}) + sum_t'(dx);
  assign sum_y = $signed({2'b00, pos_y_r}) - sum_t'(dy);
  assign new_x = hdr_r[6] ? pos_x_r : clamp_axis(sum_x, lim_x);
  assign new_y = hdr_r[7] ? pos_y_r : clamp_axis(sum_y, lim_y);

  always_comb begin
    state_nxt = state_r;
    hdr_nxt   = hdr_r;
    xb_nxt    = xb_r;
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    done      = 1'b0;
    unique case (state_r)
      PKT_HDR: begin
        xb_nxt    = byte_in;
        state_nxt = PKT_XB;
      end
      PKT_XB: begin
        done      = 1'b1;
        state_nxt = PKT_IDLE;
        pos_x_nxt = new_x;
        pos_y_nxt = new_y;
      end
      default: begin
        if (byte_in[3]) begin
          hdr_nxt   = byte_in;
          state_nxt = PKT_HDR;
        end else begin
          state_nxt = PKT_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PKT_IDLE;
      hdr_r   <= '0;
      xb_r    <= '0;
      pos_x_r <= PosReset;
      pos_y_r <= PosReset;
    end else if (en) begin
      state_r <= state_nxt;
      hdr_r   <= hdr_nxt;
      xb_r    <= xb_nxt;
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
    end
  end

  assign res_valid         = en && done;
  assign res.left_button   = hdr_r[0];
  assign res.right_button  = hdr_r[1];
  assign res.middle_button = hdr_r[2];
  assign res.x_overflow    = hdr_r[6];
  assign res.y_overflow    = hdr_r[7];
  assign res.delta_x       = dx;
  assign res.delta_y       = dy;
  assign res.cursor_x      = PortXyBits'(new_x);
  assign res.cursor_y      = PortXyBits'(new_y);

endmodule

/* src/ps2mc_out_stage.sv */
// ----------------------------------------------------------------------------
// ps2mc_out_stage
// result register holding one packet result until its transfer
// ----------------------------------------------------------------------------
module ps2mc_out_stage import ps2mc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res_in,
  input  logic out_ready,
  output logic out_valid,
  output logic free,
  output res_t res_out
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ready) valid_nxt = 1'b0;
    if (load) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res_in;
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

/* src/ps2_mouse_packet_cursor.sv */
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor
// ps2 mouse three-byte packet decoder with a clamped cursor position
//
// in_ channel: one raw mouse byte per transfer. a byte with bit 3 set opens
// a packet when none is open; stray bytes are dropped. the third byte of a
// packet yields one out_ transfer with buttons, overflow flags, 9-bit
// deltas and the new cursor position (x adds dx, y subtracts dy, each
// clamped to 0..screen minus cursor, held when its overflow flag is set).
// cfg_ channel: register writes, index 0 screen width, 1 screen height,
// 2 cursor width, 3 cursor height; always ready. they are to be written
// only while idle; the block itself does not enforce this. throughput: one
// byte per cycle while no result waits in the output register, set by
// the input register feeding the decode logic and the result register.
// a packet's third byte passes the input register before out_valid rises.
// reset: no packet open, cursor at 150,150, registers 1024, 768, 32, 32.
// stall: a pending result waits in the output register; while it waits no
// byte leaves the input register, and in_ready drops once that holds a byte.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor import ps2mc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_mouse_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_left_button,
  output logic                  out_right_button,
  output logic                  out_middle_button,
  output logic                  out_x_overflow,
  output logic                  out_y_overflow,
  output logic [DeltaBits-1:0]  out_delta_x,
  output logic [DeltaBits-1:0]  out_delta_y,
  output logic [PortXyBits-1:0] out_cursor_x,
  output logic [PortXyBits-1:0] out_cursor_y,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CfgIdxBits-1:0] cfg_index,
  input  logic [ScreenBits-1:0] cfg_data
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       adv;
  logic       out_free;
  logic       res_valid;
  res_t       res;
  res_t       res_out;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SCREEN_W: cfg_nxt.screen_w = cfg_data;
        CFG_SCREEN_H: cfg_nxt.screen_h = cfg_data;
        CFG_CURSOR_W: cfg_nxt.cursor_w = cfg_data[CursorBits-1:0];
        CFG_CURSOR_H: cfg_nxt.cursor_h = cfg_data[CursorBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_w <= ScreenBits'(1024);
      cfg_r.screen_h <= ScreenBits'(768);
      cfg_r.cursor_w <= CursorBits'(32);
      cfg_r.cursor_h <= CursorBits'(32);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign adv = s1_valid && out_free;

  ps2mc_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mouse_byte (in_mouse_byte),
    .adv           (adv),
    .s1_valid      (s1_valid),
    .s1_byte       (s1_byte)
  );

  ps2mc_decode u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .byte_in   (s1_byte),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  ps2mc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res_in    (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (out_free),
    .res_out   (res_out)
  );

  assign out_left_button   = res_out.left_button;
  assign out_right_button  = res_out.right_button;
  assign out_middle_button = res_out.middle_button;
  assign out_x_overflow    = res_out.x_overflow;
  assign out_y_overflow    = res_out.y_overflow;
  assign out_delta_x       = res_out.delta_x;
  assign out_delta_y       = res_out.delta_y;
  assign out_cursor_x      = res_out.cursor_x;
  assign out_cursor_y      = res_out.cursor_y;

  a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && s1_valid))
    else $error("in_ready low without a blocked result");

  a_reset_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result appeared without a byte in the input register");

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (!out_valid || out_ready))
    else $error("result overwrote a pending result");

endmodule
